>>> rtl/frg_pkg.sv
package frg_pkg;

	// Width of the numerator, denominator and both reduced values.
	localparam int DATA_WIDTH = 32;

	// Step counter of the serial divider: one quotient bit per cycle.
	localparam int CNT_W = $clog2(DATA_WIDTH);

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [DATA_WIDTH-1:0] mag_t;

	// Status from the serial divider to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} frg_div_stat_t;

endpackage

>>> rtl/frg_in_if.sv
interface frg_in_if;
	logic valid;
	logic ready;
	frg_pkg::data_t numerator;
	frg_pkg::data_t denominator;

	modport source (output valid, output numerator, output denominator, input ready);
	modport sink (input valid, input numerator, input denominator, output ready);
endinterface

>>> rtl/frg_out_if.sv
interface frg_out_if;
	logic valid;
	logic ready;
	frg_pkg::data_t reduced_numerator;
	frg_pkg::data_t reduced_denominator;
	logic ok;

	modport source (output valid, output reduced_numerator, output reduced_denominator,
		output ok, input ready);
	modport sink (input valid, input reduced_numerator, input reduced_denominator,
		input ok, output ready);
endinterface

>>> rtl/frg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module frg_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  frg_pkg::mag_t        dividend,
	input  frg_pkg::mag_t        divisor,
	output frg_pkg::frg_div_stat_t status,
	output frg_pkg::mag_t        quotient,
	output frg_pkg::mag_t        remainder
);

	localparam int W = frg_pkg::DATA_WIDTH;

	logic                    busy_q;
	logic                    done_q;
	logic [frg_pkg::CNT_W-1:0] cnt_q;
	frg_pkg::mag_t           rem_q;
	frg_pkg::mag_t           quo_q;
	frg_pkg::mag_t           div_q;
	logic [W+1:0]            diff;

	// Trial subtract of the divisor from the partial remainder with the next bit in.
	assign diff = {1'b0, rem_q, quo_q[W-1]} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= frg_pkg::CNT_W'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (diff[W+1]) begin
				// restore: keep the shifted remainder
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end else begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;
	assign remainder   = rem_q;

endmodule

>>> rtl/fraction_reduce_gcd.sv
// A zero denominator skips the Euclid steps and goes straight to the result.
// Requests: one at a time; the next is taken only after the result has moved to the output
// register, and the shared serial divider (one bit per cycle) serves every step.
// Reset: arst_n clears the sequencer, the divider control and the output valid.
module fraction_reduce_gcd (
	input  logic             clk,
	input  logic             arst_n,
	frg_in_if.sink           in_ch,
	frg_out_if.source        out_ch
);

	localparam int W = frg_pkg::DATA_WIDTH;

	// Sequencer states
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_EUC     = 3'd1;
	localparam logic [2:0] ST_EUC_WT  = 3'd2;
	localparam logic [2:0] ST_QN_WT   = 3'd3;
	localparam logic [2:0] ST_QD      = 3'd4;
	localparam logic [2:0] ST_QD_WT   = 3'd5;
	localparam logic [2:0] ST_DONE    = 3'd6;

	logic [2:0]             state_q;
	frg_pkg::mag_t          a_q;      // Euclid pair; a_q ends as the divisor
	frg_pkg::mag_t          b_q;
	frg_pkg::mag_t          nm_q;     // magnitudes of the request
	frg_pkg::mag_t          dm_q;
	logic                   nneg_q;
	logic                   dneg_q;
	frg_pkg::data_t         res_n_q;
	frg_pkg::data_t         res_d_q;
	logic                   res_ok_q;

	logic                   out_valid_q;
	frg_pkg::data_t         out_n_q;
	frg_pkg::data_t         out_d_q;
	logic                   out_ok_q;

	logic                   in_acc;
	logic                   out_load;
	logic                   div_start;
	frg_pkg::mag_t          div_dividend;
	frg_pkg::mag_t          div_divisor;
	frg_pkg::frg_div_stat_t div_stat;
	frg_pkg::mag_t          div_quo;
	frg_pkg::mag_t          div_rem;
	frg_pkg::mag_t          in_nm;
	frg_pkg::mag_t          in_dm;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	// Hand the finished result to the output register once that slot is free.
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);

	// Magnitudes of the request; the most negative value maps onto itself as unsigned.
	assign in_nm = in_ch.numerator[W-1]   ? frg_pkg::mag_t'(-in_ch.numerator)
	                                      : frg_pkg::mag_t'(in_ch.numerator);
	assign in_dm = in_ch.denominator[W-1] ? frg_pkg::mag_t'(-in_ch.denominator)
	                                      : frg_pkg::mag_t'(in_ch.denominator);

	// Divider operand select: remainder steps, then numerator and denominator over gcd.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = a_q;
		div_divisor  = b_q;
		case (state_q)
			ST_EUC: begin
				div_start = 1'b1;
				if (b_q == '0) begin
					div_dividend = nm_q;
					div_divisor  = a_q;
				end
			end
			ST_QD: begin
				div_start    = 1'b1;
				div_dividend = dm_q;
				div_divisor  = a_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	frg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.status    (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						// zero denominator skips straight to the result
						state_q <= (in_ch.denominator == '0) ? ST_DONE : ST_EUC;
					end
				end
				ST_EUC: begin
					state_q <= (b_q == '0) ? ST_QN_WT : ST_EUC_WT;
				end
				ST_EUC_WT: begin
					if (div_stat.done) begin
						state_q <= ST_EUC;
					end
				end
				ST_QN_WT: begin
					if (div_stat.done) begin
						state_q <= ST_QD;
					end
				end
				ST_QD: begin
					state_q <= ST_QD_WT;
				end
				ST_QD_WT: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			nm_q     <= in_nm;
			dm_q     <= in_dm;
			a_q      <= in_nm;
			b_q      <= in_dm;
			nneg_q   <= in_ch.numerator[W-1];
			dneg_q   <= in_ch.denominator[W-1];
			// pass-through values, kept when the denominator is zero
			res_n_q  <= in_ch.numerator;
			res_d_q  <= in_ch.denominator;
			res_ok_q <= 1'b0;
		end
		if (state_q == ST_EUC_WT && div_stat.done) begin
			// advance the pair: (a, b) <= (b, a mod b)
			a_q <= b_q;
			b_q <= div_rem;
		end
		if (state_q == ST_QN_WT && div_stat.done) begin
			res_n_q <= nneg_q ? frg_pkg::data_t'(-div_quo) : frg_pkg::data_t'(div_quo);
		end
		if (state_q == ST_QD_WT && div_stat.done) begin
			res_d_q  <= dneg_q ? frg_pkg::data_t'(-div_quo) : frg_pkg::data_t'(div_quo);
			res_ok_q <= 1'b1;
		end
	end

	// Output register: hold the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_n_q  <= res_n_q;
			out_d_q  <= res_d_q;
			out_ok_q <= res_ok_q;
		end
	end

	assign out_ch.valid               = out_valid_q;
	assign out_ch.reduced_numerator   = out_n_q;
	assign out_ch.reduced_denominator = out_d_q;
	assign out_ch.ok                  = out_ok_q;

	// Never restart the divider in the middle of a division.
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	// A cleared ok flag only ever comes from a zero denominator.
	a_not_ok_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ok) |-> (out_ch.reduced_denominator == '0))
		else $error("ok cleared with nonzero denominator");

	// A reduced fraction never has a zero denominator.
	a_ok_nonzero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ok) |-> (out_ch.reduced_denominator != '0))
		else $error("reduced denominator is zero");

	// Divider completion is only seen while the sequencer waits for it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_EUC_WT || state_q == ST_QN_WT
			|| state_q == ST_QD_WT))
		else $error("divider done outside a wait state");

endmodule
